// ----- rtl/rlpl_pkg.sv -----
package rlpl_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ADDR_W = 32;
   localparam int IFACE_W = 3;
   localparam int INDEX_W = 4;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [IFACE_W-1:0] iface_type;
   typedef logic [ENTRY_W-1:0] entry_idx_type;

   // One route table entry as presented to the compare unit.
   typedef struct packed {
      logic      used;
      addr_type  dest;
      addr_type  mask;
      addr_type  hop;
      iface_type port;
   } route_entry_type;

   // Running best match of the scan in progress.
   typedef struct packed {
      logic     hit;
      addr_type mask;
   } best_type;

   // Decision of the compare unit for the entry under test.
   typedef struct packed {
      logic     take;
      addr_type hop;
   } verdict_type;

endpackage

// ----- rtl/rlpl_cmp.sv -----
module rlpl_cmp (
   input  rlpl_pkg::addr_type        addr,
   input  rlpl_pkg::route_entry_type entry,
   input  rlpl_pkg::best_type        best,
   output rlpl_pkg::verdict_type     verdict
);

   logic match;
   logic longer;

   assign match = entry.used && ((addr & entry.mask) == entry.dest);

   // A mask equal to the best so far still wins, so the later entry takes a tie.
   assign longer = !best.hit || (entry.mask >= best.mask);

   assign verdict.take = match && longer;

   // A zero next hop means the destination is directly attached.
   assign verdict.hop = (entry.hop == '0) ? addr : entry.hop;

endmodule

// ----- rtl/route_longest_prefix_lookup.sv -----
// Longest-prefix route lookup over a small table. A write word (kind 0) loads
// one table slot in the cycle it is accepted and produces no response, so write
// words can be taken back to back. A lookup word (kind 1) walks the table one
// entry per cycle through a single shared mask-and-compare unit, keeping the
// best match (largest mask, later entry on a tie), then holds one response word
// until it is taken. Each entry is read into a register in the cycle before it
// is compared. A lookup keeps req_ready low while it scans all TABLE_ENTRIES
// entries and while its response word waits to be taken, so no new word is
// accepted until the response has been taken.
// The table valid bits are cleared by reset, so no clearing pass is needed.
module route_longest_prefix_lookup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [rlpl_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic                            req_entry_valid,
   input  rlpl_pkg::addr_type              req_entry_dest,
   input  rlpl_pkg::addr_type              req_entry_mask,
   input  rlpl_pkg::addr_type              req_entry_next_hop,
   input  rlpl_pkg::iface_type             req_entry_iface,
   input  rlpl_pkg::addr_type              req_lookup_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output rlpl_pkg::addr_type              rsp_next_hop_addr,
   output rlpl_pkg::iface_type             rsp_out_iface
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   localparam rlpl_pkg::entry_idx_type LAST_IDX =
      rlpl_pkg::ENTRY_W'(rlpl_pkg::TABLE_ENTRIES - 1);

   rlpl_pkg::addr_type  dest_ff [rlpl_pkg::TABLE_ENTRIES];
   rlpl_pkg::addr_type  mask_ff [rlpl_pkg::TABLE_ENTRIES];
   rlpl_pkg::addr_type  hop_tab_ff [rlpl_pkg::TABLE_ENTRIES];
   rlpl_pkg::iface_type port_ff [rlpl_pkg::TABLE_ENTRIES];
   logic [rlpl_pkg::TABLE_ENTRIES-1:0] used_ff;

   logic [1:0]                state_ff, state_in;
   rlpl_pkg::entry_idx_type   idx_ff, idx_in;
   rlpl_pkg::addr_type        addr_ff, addr_in;
   logic                      hit_ff, hit_in;
   rlpl_pkg::addr_type        best_mask_ff, best_mask_in;
   rlpl_pkg::addr_type        hop_ff, hop_in;
   rlpl_pkg::iface_type       iface_ff, iface_in;

   logic                      req_take;
   logic                      wr_en;
   rlpl_pkg::entry_idx_type   wr_idx;
   rlpl_pkg::route_entry_type cur_entry_ff;
   rlpl_pkg::best_type        best;
   rlpl_pkg::verdict_type     verdict;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign wr_en     = req_take && !req_kind &&
                      (32'(req_entry_index) < rlpl_pkg::TABLE_ENTRIES);
   assign wr_idx    = rlpl_pkg::ENTRY_W'(req_entry_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_en) begin
         used_ff[wr_idx] <= req_entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dest_ff[wr_idx]    <= req_entry_dest;
         mask_ff[wr_idx]    <= req_entry_mask;
         hop_tab_ff[wr_idx] <= req_entry_next_hop;
         port_ff[wr_idx]    <= req_entry_iface;
      end
   end

   // The entry compared in the next cycle is fetched at the index that the
   // sequencer moves to. No write can land while a scan is running.
   always_ff @(posedge clock) begin
      cur_entry_ff.used <= used_ff[idx_in];
      cur_entry_ff.dest <= dest_ff[idx_in];
      cur_entry_ff.mask <= mask_ff[idx_in];
      cur_entry_ff.hop  <= hop_tab_ff[idx_in];
      cur_entry_ff.port <= port_ff[idx_in];
   end

   assign best.hit  = hit_ff;
   assign best.mask = best_mask_ff;

   rlpl_cmp u_cmp (
      .addr    (addr_ff),
      .entry   (cur_entry_ff),
      .best    (best),
      .verdict (verdict)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      best_mask_in = best_mask_ff;
      hop_in       = hop_ff;
      iface_in     = iface_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_kind) begin
               state_in     = ST_SCAN;
               idx_in       = '0;
               addr_in      = req_lookup_addr;
               hit_in       = 1'b0;
               best_mask_in = '0;
               hop_in       = '0;
               iface_in     = '0;
            end
         end
         ST_SCAN: begin
            if (verdict.take) begin
               hit_in       = 1'b1;
               best_mask_in = cur_entry_ff.mask;
               hop_in       = verdict.hop;
               iface_in     = cur_entry_ff.port;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         best_mask_ff <= '0;
         hop_ff       <= '0;
         iface_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         best_mask_ff <= best_mask_in;
         hop_ff       <= hop_in;
         iface_ff     <= iface_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_found         = hit_ff;
   assign rsp_next_hop_addr = hop_ff;
   assign rsp_out_iface     = iface_ff;

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while a response word is pending");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_next_hop_addr == '0 && rsp_out_iface == '0))
      else $error("miss response carries nonzero next hop or interface");

   a_lookup_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_kind) |=> (state_ff == ST_SCAN && idx_ff == '0 && !hit_ff))
      else $error("lookup did not start a fresh scan");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_kind) |=> (req_ready && !rsp_valid))
      else $error("write word left the block busy");

   a_scan_ends_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && idx_ff == LAST_IDX) |=> rsp_valid)
      else $error("scan of the last entry did not produce a response");

endmodule
